@@ rtl/c_integer_literal_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the integer literal parser
// Concurrent checks on the rising clock edge, muted while reset is low.
// ----------------------------------------------------------------------------
`ifndef C_INTEGER_LITERAL_PARSER_UNIT_ASSERT_SVH
`define C_INTEGER_LITERAL_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CILP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CILP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CILP_ASSERT_SAME(lbl, ante, cons, msg)
`define CILP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/cilp_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer literal parser package
// Shared widths, character codes and the token and result records.
// ----------------------------------------------------------------------------
package cilp_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int MAG_W       = 64;
    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = 4;
    localparam int LCOUNT_W    = 2;
    localparam int TOKQ_DEPTH  = 4;
    localparam int TOKQ_AW     = $clog2(TOKQ_DEPTH);
    localparam int TOKQ_CW     = $clog2(TOKQ_DEPTH + 1);
    localparam int RESQ_DEPTH  = 2;
    localparam int RESQ_AW     = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW     = $clog2(RESQ_DEPTH + 1);

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_LA = 8'h61;
    localparam logic [7:0] CH_LF = 8'h66;
    localparam logic [7:0] CH_UA = 8'h41;
    localparam logic [7:0] CH_UF = 8'h46;
    localparam logic [7:0] CH_LX = 8'h78;
    localparam logic [7:0] CH_UX = 8'h58;
    localparam logic [7:0] CH_LU = 8'h75;
    localparam logic [7:0] CH_UU = 8'h55;
    localparam logic [7:0] CH_LL = 8'h6c;
    localparam logic [7:0] CH_UL = 8'h4c;

    localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;

    typedef struct packed {
        logic               digit_ok;
        logic [DIGIT_W-1:0] digit;
        logic               is_zero;
        logic               is_x;
        logic               is_u;
        logic               is_l;
        logic               last;
    } t_tok;

    typedef struct packed {
        logic                ok;
        logic [MAG_W-1:0]    magnitude;
        logic [RADIX_W-1:0]  radix;
        logic                unsigned_suffix;
        logic [LCOUNT_W-1:0] long_suffix_count;
    } t_res;

endpackage

@@ rtl/cilp_front.sv @@
// ----------------------------------------------------------------------------
// Integer literal parser front end
// Classifies each character into a token and queues it for the back end.
// ----------------------------------------------------------------------------
module cilp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_character,
    input  logic          i_last_char,
    output logic          o_full,
    output logic          o_tok_valid,
    output cilp_pkg::t_tok o_tok,
    input  logic          i_tok_pop
);
    import cilp_pkg::*;

    t_tok               r_mem [TOKQ_DEPTH];
    logic [TOKQ_AW-1:0] r_wp;
    logic [TOKQ_AW-1:0] r_rp;
    logic [TOKQ_CW-1:0] r_cnt;
    logic [TOKQ_CW-1:0] n_cnt;
    t_tok               cls;
    logic               wr_en;
    logic               rd_en;

    always_comb begin
        cls          = '0;
        cls.last     = i_last_char;
        cls.is_zero  = (i_character == CH_0);
        cls.is_x     = (i_character == CH_LX) || (i_character == CH_UX);
        cls.is_u     = (i_character == CH_LU) || (i_character == CH_UU);
        cls.is_l     = (i_character == CH_LL) || (i_character == CH_UL);
        if (i_character >= CH_0 && i_character <= CH_9) begin
            cls.digit_ok = 1'b1;
            cls.digit    = i_character[DIGIT_W-1:0];
        end else if (i_character >= CH_LA && i_character <= CH_LF) begin
            cls.digit_ok = 1'b1;
            cls.digit    = DIGIT_W'(i_character - CH_LA + 8'd10);
        end else if (i_character >= CH_UA && i_character <= CH_UF) begin
            cls.digit_ok = 1'b1;
            cls.digit    = DIGIT_W'(i_character - CH_UA + 8'd10);
        end
    end

    assign o_full      = (r_cnt == TOKQ_CW'(TOKQ_DEPTH));
    assign o_tok_valid = (r_cnt != '0);
    assign o_tok       = r_mem[r_rp];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_tok_pop && o_tok_valid;

    always_comb begin
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + TOKQ_CW'(1);
            2'b01:   n_cnt = r_cnt - TOKQ_CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + TOKQ_AW'(1);
            end
            if (rd_en) begin
                r_rp <= r_rp + TOKQ_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/cilp_back.sv @@
// ----------------------------------------------------------------------------
// Integer literal parser back end
// Runs the prefix, digit and suffix sequencer and folds digits into the value.
// ----------------------------------------------------------------------------
module cilp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tok_valid,
    input  cilp_pkg::t_tok i_tok,
    output logic           o_tok_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output cilp_pkg::t_res o_res
);
    import cilp_pkg::*;

    localparam logic [2:0] PH_FIRST  = 3'd0;
    localparam logic [2:0] PH_ZERO   = 3'd1;
    localparam logic [2:0] PH_HEXPFX = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_SUFFIX = 3'd4;

    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam int SUM_W = VALUE_BITS + 4;

    logic [2:0]            r_phase,  n_phase;
    logic [VALUE_BITS-1:0] r_acc,    n_acc;
    logic [1:0]            r_base,   n_base;
    logic                  r_failed, n_failed;
    logic                  r_uns,    n_uns;
    logic [LCOUNT_W-1:0]   r_lc,     n_lc;

    logic                  suffix;
    logic                  do_digit;
    logic                  do_suffix;
    logic [RADIX_W-1:0]    radix;
    logic [SUM_W-1:0]      scaled;
    logic [SUM_W-1:0]      sum;
    logic                  good;

    assign suffix     = i_tok.is_u || i_tok.is_l;
    assign o_tok_pop  = i_tok_valid && (!i_tok.last || !i_res_full);
    assign o_res_push = o_tok_pop && i_tok.last;

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_base    = r_base;
        n_failed  = r_failed;
        n_uns     = r_uns;
        n_lc      = r_lc;
        do_digit  = 1'b0;
        do_suffix = 1'b0;

        unique case (r_phase)
            PH_ZERO: begin
                if (i_tok.is_x) begin
                    n_phase = PH_HEXPFX;
                end else if (suffix) begin
                    do_suffix = 1'b1;
                    n_phase   = PH_SUFFIX;
                end else begin
                    n_base   = BASE_OCT;
                    n_phase  = PH_DIGITS;
                    do_digit = 1'b1;
                end
            end
            PH_HEXPFX: begin
                if (suffix) begin
                    do_suffix = 1'b1;
                    n_failed  = 1'b1;
                    n_phase   = PH_SUFFIX;
                end else begin
                    n_base   = BASE_HEX;
                    n_phase  = PH_DIGITS;
                    do_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (suffix) begin
                    do_suffix = 1'b1;
                    n_phase   = PH_SUFFIX;
                end else begin
                    do_digit = 1'b1;
                end
            end
            PH_SUFFIX: begin
                if (suffix) begin
                    do_suffix = 1'b1;
                end else begin
                    n_failed = 1'b1;
                end
            end
            default: begin
                if (i_tok.is_zero) begin
                    n_phase = PH_ZERO;
                end else if (suffix) begin
                    do_suffix = 1'b1;
                    n_failed  = 1'b1;
                    n_phase   = PH_SUFFIX;
                end else begin
                    n_base   = BASE_DEC;
                    n_phase  = PH_DIGITS;
                    do_digit = 1'b1;
                end
            end
        endcase

        unique case (n_base)
            BASE_HEX: begin
                radix  = RADIX_HEX;
                scaled = SUM_W'({r_acc, 4'b0000});
            end
            BASE_OCT: begin
                radix  = RADIX_OCT;
                scaled = SUM_W'({r_acc, 3'b000});
            end
            default: begin
                radix  = RADIX_DEC;
                scaled = SUM_W'({r_acc, 3'b000}) + SUM_W'({r_acc, 1'b0});
            end
        endcase
        sum = scaled + SUM_W'(i_tok.digit);

        if (do_digit) begin
            if (!i_tok.digit_ok || {1'b0, i_tok.digit} >= radix
                    || (sum[SUM_W-1:VALUE_BITS] != '0)) begin
                n_failed = 1'b1;
            end else begin
                n_acc = sum[VALUE_BITS-1:0];
            end
        end

        if (do_suffix) begin
            if (i_tok.is_u) begin
                n_uns = 1'b1;
            end else if (r_lc != '1) begin
                n_lc = r_lc + LCOUNT_W'(1);
            end
        end

        good = !n_failed && n_phase != PH_HEXPFX && n_phase != PH_FIRST;
        o_res.ok                = good;
        o_res.magnitude         = good ? MAG_W'(n_acc) : '0;
        o_res.radix             = good ? radix : RADIX_DEC;
        o_res.unsigned_suffix   = good && n_uns;
        o_res.long_suffix_count = good ? n_lc : '0;

        if (i_tok.last) begin
            n_phase  = PH_FIRST;
            n_acc    = '0;
            n_base   = BASE_DEC;
            n_failed = 1'b0;
            n_uns    = 1'b0;
            n_lc     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_acc    <= '0;
            r_base   <= BASE_DEC;
            r_failed <= 1'b0;
            r_uns    <= 1'b0;
            r_lc     <= '0;
        end else if (o_tok_pop) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_base   <= n_base;
            r_failed <= n_failed;
            r_uns    <= n_uns;
            r_lc     <= n_lc;
        end
    end

endmodule

@@ rtl/cilp_resq.sv @@
// ----------------------------------------------------------------------------
// Integer literal parser result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module cilp_resq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cilp_pkg::t_res i_res,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output cilp_pkg::t_res o_head
);
    import cilp_pkg::*;

    t_res               r_mem [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wp;
    logic [RESQ_AW-1:0] r_rp;
    logic [RESQ_CW-1:0] r_cnt;
    logic [RESQ_CW-1:0] n_cnt;
    logic               wr_en;
    logic               rd_en;

    assign o_full  = (r_cnt == RESQ_CW'(RESQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        case ({wr_en, rd_en})
            2'b10:   n_cnt = r_cnt + RESQ_CW'(1);
            2'b01:   n_cnt = r_cnt - RESQ_CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + RESQ_AW'(1);
            end
            if (rd_en) begin
                r_rp <= r_rp + RESQ_AW'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/c_integer_literal_parser_unit.sv @@
// ----------------------------------------------------------------------------
// C integer literal parser
// Takes one character per beat and returns one result per literal on its
// last character: ok flag, value, base, unsigned flag and long count. The
// unit sustains one character per clock while neither queue is full; the bound
// is the back end's value update, one multiply-by-base and add per character.
// A pushed character is classified into a four-entry token queue; the back
// end pops tokens from it and, on the last character, writes the result into
// the output queue, from which it can then be popped. The token queue lets
// the input keep flowing while the two-entry result queue waits on pop.
// ----------------------------------------------------------------------------
`include "c_integer_literal_parser_unit_assert.svh"

module c_integer_literal_parser_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic [7:0]                             i_character,
    input  logic                                   i_last_char,
    output logic                                   o_empty,
    input  logic                                   i_pop,
    output logic                                   o_ok,
    output logic [cilp_pkg::MAG_W-1:0]             o_magnitude,
    output logic [cilp_pkg::RADIX_W-1:0]           o_radix,
    output logic                                   o_unsigned_suffix,
    output logic [cilp_pkg::LCOUNT_W-1:0]          o_long_suffix_count
);
    import cilp_pkg::*;

    logic tok_valid;
    t_tok tok;
    logic tok_pop;
    logic res_full;
    logic res_push;
    t_res res;
    t_res head;

    cilp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .o_full      (o_full),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_pop   (tok_pop)
    );

    cilp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    cilp_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res),
        .o_full  (res_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_head  (head)
    );

    assign o_ok                = head.ok;
    assign o_magnitude         = head.magnitude;
    assign o_radix             = head.radix;
    assign o_unsigned_suffix   = head.unsigned_suffix;
    assign o_long_suffix_count = head.long_suffix_count;

    `CILP_ASSERT_SAME(a_fail_clean, !o_empty && !o_ok, o_magnitude == '0 && o_radix == RADIX_DEC && !o_unsigned_suffix && o_long_suffix_count == '0, "failed result not cleared")
    `CILP_ASSERT_SAME(a_radix_legal, !o_empty, o_radix == RADIX_OCT || o_radix == RADIX_DEC || o_radix == RADIX_HEX, "illegal radix")
    `CILP_ASSERT_NEXT(a_last_held, tok_valid && tok.last && res_full, tok_valid && $stable(tok), "last token lost on full result queue")

endmodule
